>>> rtl/crctl_pkg.sv
// ----------------------------------------------------------------------------
// crctl_pkg
// Shared types, character constants and CRC-32 helpers for the CRC tagged
// line stream block.
// ----------------------------------------------------------------------------
package crctl_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [3:0] NIB_MASK    = 4'h F;

    // Positions in the output sequence of one queue entry.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_OPEN     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_OPEN_LF  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_OPEN_TAG = 5'd2;
    localparam logic [STEP_W-1:0] STEP_CHAR     = 5'd13;
    localparam logic [STEP_W-1:0] STEP_TAG      = 5'd14;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd24;

    // One classified character waiting for the back end.
    typedef struct packed {
        logic [7:0]  ch;
        logic        first;
        logic        newline;
        logic [31:0] tag;
    } t_queue_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // Byte-wise reflected CRC-32 update.
    function automatic logic [31:0] crc_fold(input logic [31:0] crc,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'(CHAR_ZERO + {4'd0, nib});
        end else begin
            r = 8'(CHAR_A + {4'd0, nib} - 8'd10);
        end
        return r;
    endfunction

    // Byte idx of the tag "{hhhhhhhh} ", idx 0 to 10.
    function automatic logic [7:0] tag_byte(input logic [3:0] idx,
                                            input logic [31:0] val);
        logic [7:0] r;
        logic [2:0] k;
        logic [3:0] nib;
        k   = 3'(4'd8 - idx);
        nib = val[{k, 2'b00} +: 4] & NIB_MASK;
        if (idx == 4'd0) begin
            r = CHAR_LBRACE;
        end else if (idx == 4'd9) begin
            r = CHAR_RBRACE;
        end else if (idx == 4'd10) begin
            r = CHAR_SPACE;
        end else begin
            r = hex_char(nib);
        end
        return r;
    endfunction

endpackage

>>> rtl/crctl_if.sv
// ----------------------------------------------------------------------------
// crctl_if
// Valid/ready stream interfaces for the input and output channels.
// ----------------------------------------------------------------------------
interface crctl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_in_write;

    modport source (output valid, output in_char, output last_in_write, input ready);
    modport sink   (input valid, input in_char, input last_in_write, output ready);
endinterface

interface crctl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> rtl/crctl_front.sv
// ----------------------------------------------------------------------------
// crctl_front
// Accepts characters, folds them into the running CRC and queues them.
// ----------------------------------------------------------------------------
module crctl_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    crctl_in_if.sink                i_in,
    input  crctl_pkg::t_fifo_status i_status,
    output logic                    o_push,
    output crctl_pkg::t_queue_entry o_entry
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic        r_started;
    logic        accept;

    assign i_in.ready = !i_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign n_crc      = crctl_pkg::crc_fold(r_crc, i_in.in_char);

    // The write-call marker does not change the output stream.
    always_comb begin
        o_push          = accept;
        o_entry.ch      = i_in.in_char;
        o_entry.first   = !r_started;
        o_entry.newline = (i_in.in_char == crctl_pkg::CHAR_LF);
        o_entry.tag     = ~n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= crctl_pkg::CRC_INIT;
            r_started <= 1'b0;
        end else if (accept) begin
            r_crc     <= n_crc;
            r_started <= 1'b1;
        end
    end

endmodule

>>> rtl/crctl_fifo.sv
// ----------------------------------------------------------------------------
// crctl_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module crctl_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  crctl_pkg::t_queue_entry i_entry,
    input  logic                    i_pop,
    output crctl_pkg::t_queue_entry o_head,
    output crctl_pkg::t_fifo_status o_status
);

    crctl_pkg::t_queue_entry r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

endmodule

>>> rtl/crctl_back.sv
// ----------------------------------------------------------------------------
// crctl_back
// Expands each queued character into its output bytes, one per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
module crctl_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  crctl_pkg::t_queue_entry i_head,
    input  crctl_pkg::t_fifo_status i_status,
    output logic                    o_pop,
    crctl_out_if.source             o_out
);

    localparam logic [31:0] OPEN_TAG_VAL = ~crctl_pkg::CRC_INIT;

    logic                          r_valid;
    logic                          n_valid;
    logic [7:0]                    r_char;
    logic                          r_last;
    logic                          r_mid;
    logic [crctl_pkg::STEP_W-1:0]  r_step;
    logic [crctl_pkg::STEP_W-1:0]  cur_step;
    logic [7:0]                    byte_out;
    logic                          last;
    logic                          emit;

    assign o_out.valid       = r_valid;
    assign o_out.out_char    = r_char;
    assign o_out.last_of_run = r_last;

    always_comb begin
        if (r_mid) begin
            cur_step = r_step;
        end else if (i_head.first) begin
            cur_step = crctl_pkg::STEP_OPEN;
        end else begin
            cur_step = crctl_pkg::STEP_CHAR;
        end

        if (cur_step == crctl_pkg::STEP_OPEN) begin
            byte_out = crctl_pkg::CHAR_CR;
        end else if (cur_step == crctl_pkg::STEP_OPEN_LF) begin
            byte_out = crctl_pkg::CHAR_LF;
        end else if (cur_step < crctl_pkg::STEP_CHAR) begin
            byte_out = crctl_pkg::tag_byte(4'(cur_step - crctl_pkg::STEP_OPEN_TAG),
                                           OPEN_TAG_VAL);
        end else if (cur_step == crctl_pkg::STEP_CHAR) begin
            byte_out = i_head.ch;
        end else begin
            byte_out = crctl_pkg::tag_byte(4'(cur_step - crctl_pkg::STEP_TAG),
                                           i_head.tag);
        end

        last  = ((cur_step == crctl_pkg::STEP_CHAR) && !i_head.newline)
                || (cur_step == crctl_pkg::STEP_LAST);
        emit  = !i_status.empty && (!r_valid || o_out.ready);
        o_pop = emit && last;

        n_valid = r_valid;
        if (emit) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mid   <= 1'b0;
            r_step  <= crctl_pkg::STEP_OPEN;
        end else begin
            r_valid <= n_valid;
            if (emit) begin
                r_mid  <= !last;
                r_step <= cur_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= byte_out;
            r_last <= last;
        end
    end

    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> !i_status.empty)
        else $error("entry left the queue before its last byte");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> (r_step > crctl_pkg::STEP_OPEN) && (r_step <= crctl_pkg::STEP_LAST))
        else $error("output step out of range");

endmodule

>>> rtl/crc_tagged_line_stream_top.sv
// ----------------------------------------------------------------------------
// crc_tagged_line_stream_top
// Console character stream with CRC-32 line tags.
// ----------------------------------------------------------------------------
// Characters arrive on i_in (in_char, last_in_write) and leave on o_out
// (out_char, last_of_run); a transaction on either channel happens at a
// rising edge with valid and ready both high. Every character is passed on
// and folded into a reflected IEEE CRC-32 (all ones start, inverted when
// shown). The first character after reset is preceded by CR, LF and the
// tag "{00000000} ". A newline is followed by "{hhhhhhhh} ", the CRC of all
// characters so far in lower-case hex, most significant digit first.
// last_of_run marks the final output byte caused by one input character;
// last_in_write has no effect on the output.
// The front end takes one character per cycle while the two-entry queue
// has room; the back end puts out one byte per cycle from its output
// register while the receiver takes them. An idle block writes a
// character into the queue and then its first byte into the output
// register, which raises o_out.valid.
// When the receiver stalls, the output register holds its byte, the queue
// fills and i_in.ready drops. Synchronous reset (i_rst_n low) restores the
// CRC to all ones, re-arms the opening tag and empties the queue.
// ----------------------------------------------------------------------------
module crc_tagged_line_stream_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crctl_in_if.sink    i_in,
    crctl_out_if.source o_out
);

    crctl_pkg::t_queue_entry push_entry;
    crctl_pkg::t_queue_entry head_entry;
    crctl_pkg::t_fifo_status fifo_status;
    logic                    push;
    logic                    pop;

    // Front end: handshake, CRC update and classification.
    crctl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (fifo_status),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Queue that lets the front keep accepting during tag bursts.
    crctl_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (fifo_status)
    );

    // Back end: byte sequencer and output register.
    crctl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_status (fifo_status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

>>> tb/tb_crc_tagged_line_stream_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_tagged_line_stream_top
// Self-checking testbench for the CRC tagged line stream block. Console
// characters are fed through the input channel. A scoreboard keeps its own
// running CRC-32 and works out every byte the serial side should show,
// opening tag and line tags included. Both channels idle and stall in random
// bursts, and once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_crc_tagged_line_stream_top;

    // One byte as it should appear on the serial side.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_serial_byte;

    // Scoreboard: tracks the CRC and the opening-tag flag the way the block
    // should, and holds the serial bytes still owed by the block.
    class line_tag_board;
        logic [31:0]  crc_reg;
        bit           opened;
        t_serial_byte owed_bytes[$];
        int           errors;

        function new();
            crc_reg = crctl_pkg::CRC_INIT;
            opened  = 1'b0;
            errors  = 0;
        endfunction

        // Reflected CRC-32, one data bit at a time, LSB first.
        function logic [31:0] fold_char(input logic [31:0] c,
                                        input logic [7:0] d);
            for (int i = 0; i < 8; i++) begin
                c = (c[0] ^ d[i]) ? ((c >> 1) ^ crctl_pkg::CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function logic [7:0] hex_digit(input logic [3:0] nib);
            return (nib < 4'd10) ? 8'(crctl_pkg::CHAR_ZERO + nib)
                                 : 8'(crctl_pkg::CHAR_A + nib - 4'd10);
        endfunction

        function void push_byte(input logic [7:0] ch, input logic last);
            t_serial_byte b;
            b.out_char    = ch;
            b.last_of_run = last;
            owed_bytes.push_back(b);
        endfunction

        // Tag of the current CRC: brace, eight hex digits, brace, space.
        function void push_tag(input logic last);
            logic [31:0] shown;
            shown = ~crc_reg;
            push_byte(crctl_pkg::CHAR_LBRACE, 1'b0);
            for (int i = 7; i >= 0; i--) begin
                push_byte(hex_digit(shown[4*i +: 4]), 1'b0);
            end
            push_byte(crctl_pkg::CHAR_RBRACE, 1'b0);
            push_byte(crctl_pkg::CHAR_SPACE, last);
        endfunction

        // Called for each accepted input transaction.
        function void note_char(input logic [7:0] ch);
            if (!opened) begin
                push_byte(crctl_pkg::CHAR_CR, 1'b0);
                push_byte(crctl_pkg::CHAR_LF, 1'b0);
                push_tag(1'b0);
                opened = 1'b1;
            end
            crc_reg = fold_char(crc_reg, ch);
            push_byte(ch, ch != crctl_pkg::CHAR_LF);
            if (ch == crctl_pkg::CHAR_LF) begin
                push_tag(1'b1);
            end
        endfunction

        // Called for each accepted output transaction.
        function void check_byte(input logic [7:0] ch, input logic last);
            t_serial_byte e;
            if (owed_bytes.size() == 0) begin
                $error("unexpected output transaction: out_char=%h last_of_run=%b",
                       ch, last);
                errors++;
            end else begin
                e = owed_bytes.pop_front();
                if (ch !== e.out_char) begin
                    $error("out_char mismatch: expected %h, actual %h", e.out_char, ch);
                    errors++;
                end
                if (last !== e.last_of_run) begin
                    $error("last_of_run mismatch: expected %b, actual %b",
                           e.last_of_run, last);
                    errors++;
                end
            end
        endfunction

        function int owed();
            return owed_bytes.size();
        endfunction
    endclass

    // The longest quiet stretch is the receiver's deliberate hold-off of
    // HOLD_CYCLES; the watchdog limit sits well above it.
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 360;
    localparam int CALM_ITEMS    = 60;
    localparam int TAIL_CYCLES   = 30;

    logic clk;
    logic rst_n;

    crctl_in_if  in_ch ();
    crctl_out_if out_ch ();

    line_tag_board board = new();

    // Run state of the sender, the receiver and the watchdog.
    int chars_sent  = 0;
    bit calm        = 1'b0;
    bit held_long   = 1'b0;
    int quiet_count = 0;

    crc_tagged_line_stream_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 50 MHz clock: 10 ns high, 10 ns low.
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one character and wait until the block accepts it. A random
    // idle burst may come first, except in the calm tail of the run. When
    // no burst is taken, valid simply stays high from the previous
    // transaction, so it never sees two updates in one time step.
    task automatic send_char(input logic [7:0] ch, input logic lw);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_char       <= ch;
        in_ch.last_in_write <= lw;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_char(ch);
        chars_sent++;
    endtask

    // Mostly printable text broken into lines, with some raw bytes mixed in
    // so that every bit of the character takes both values.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 9) begin
            return crctl_pkg::CHAR_LF;
        end else if (r < 75) begin
            return 8'($urandom_range(32, 126));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Stimulus and end of run.
    initial begin
        logic [7:0] directed_chars[$];
        in_ch.valid         <= 1'b0;
        in_ch.in_char       <= 8'h00;
        in_ch.last_in_write <= 1'b0;
        rst_n               <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The very first character is a newline, so the opening sequence
        // and a line tag come out back to back: the longest run of bytes.
        // Then byte extremes, tag-like and control characters, and two
        // newlines in a row so a tag follows a tag.
        directed_chars = '{crctl_pkg::CHAR_LF, 8'h00, 8'hFF, crctl_pkg::CHAR_CR,
                           8'h61, crctl_pkg::CHAR_LBRACE, crctl_pkg::CHAR_RBRACE,
                           8'h80, 8'h7F, crctl_pkg::CHAR_LF, crctl_pkg::CHAR_LF,
                           8'h55, 8'hAA, 8'h0B, 8'h09, crctl_pkg::CHAR_SPACE,
                           8'h30, 8'h66, crctl_pkg::CHAR_LF, 8'h01,
                           crctl_pkg::CHAR_LF};
        foreach (directed_chars[i]) begin
            send_char(directed_chars[i], 1'(i % 2));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            send_char(pick_char(), 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;

        // Drain: the watchdog ends the run if the block stops answering.
        while (board.owed() != 0) @(posedge clk);
        // The tail wait catches any byte the block should not send.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0) begin
            $display("tb_crc_tagged_line_stream_top passed");
        end else begin
            $display("tb_crc_tagged_line_stream_top failed");
        end
        $finish;
    end

    // Receiver. It stalls in random bursts, and once, after enough traffic,
    // holds ready low for HOLD_CYCLES while the sender keeps offering, so the
    // output register and the queue fill and the block stalls its input.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_long && chars_sent >= 80) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_long = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Output monitor and watchdog. Signals are read in the active region of
    // the clock edge, before any nonblocking update of that edge lands.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                board.check_byte(out_ch.out_char, out_ch.last_of_run);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("tb_crc_tagged_line_stream_top failed");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
rtl/crctl_pkg.sv
rtl/crctl_if.sv
rtl/crctl_front.sv
rtl/crctl_fifo.sv
rtl/crctl_back.sv
rtl/crc_tagged_line_stream_top.sv
tb/tb_crc_tagged_line_stream_top.sv
